// ----- rtl/core/saa_pkg.sv -----
// ----------------------------------------------------------------------------
// saa_pkg
// Shared types and constants of the stack arena allocator: field widths,
// request and status codes and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package saa_pkg;

   // Widths of the offset and size fields and of the configuration register.
   localparam int OFS_W       = 25;
   localparam int CFG_W       = 9;
   // One commit block is 64 KiB.
   localparam int BLOCK_SHIFT = 16;

   // Request codes.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NO_SPACE     = 2'd1,
      STATUS_FREE_IGNORED = 2'd2,
      STATUS_STACK_FULL   = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_GROW,
      ST_SCAN,
      ST_POP,
      ST_SHRINK
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/saa_ram.sv -----
// ----------------------------------------------------------------------------
// saa_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered so that it appears in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module saa_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/stack_arena_allocator.sv -----
// ----------------------------------------------------------------------------
// stack_arena_allocator
// Bump arena over one buffer with a chunk stack held in a RAM. Allocations
// push chunks, frees mark them and pop every freed chunk from the top.
// ----------------------------------------------------------------------------
// Sequence from start to result: an allocate checks and pushes in ST_ALLOC, then
//   grows the commit in ST_GROW steps if needed; a null free or a free on an empty
//   stack answers from ST_IDLE; any other free compares chunks from the top in ST_SCAN
//   (one RAM read a cycle), reads chunks while popping in ST_POP and, unless ignored, shrinks in ST_SHRINK.
// busy is high until the result, so one item at a time; results cannot stall.
// Synchronous reset empties the stack, clears the bump pointer, commits 1 block.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_arena_allocator
   import saa_pkg::*;
#(
   parameter int BUFFER_MAX_BYTES = 16777216,
   parameter int BUFFER_MIN_BYTES = 65536,
   parameter int CHUNK_DEPTH      = 256,
   parameter int HEADER_BYTES     = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // Request channel.
   input  wire logic             start,
   output logic                  busy,
   input  wire logic             req_type,
   input  wire logic [OFS_W-1:0] req_alloc_size,
   input  wire logic [OFS_W-1:0] req_free_offset,
   // Result channel.
   output logic                  rsp_valid,
   output logic      [OFS_W-1:0] rsp_body_offset,
   output logic      [1:0]       rsp_status,
   output logic      [OFS_W-1:0] rsp_committed_bytes,
   // Configuration register.
   input  wire logic             csr_wr_en,
   input  wire logic [CFG_W-1:0] csr_wr_data
);

   // Address arithmetic width: covers a body plus a full size field.
   localparam int AW = $clog2(BUFFER_MAX_BYTES + HEADER_BYTES + 4 + (1 << OFS_W)) + 1;
   localparam int GW = AW + 2;
   localparam int IW = $clog2(CHUNK_DEPTH);
   localparam int CW = $clog2(CHUNK_DEPTH + 1);
   localparam int MW = AW + OFS_W + 1;

   localparam logic [AW-1:0] MAX_B      = AW'(BUFFER_MAX_BYTES);
   localparam logic [AW-1:0] MIN_B      = AW'(BUFFER_MIN_BYTES);
   localparam logic [GW-1:0] MAX_WIDE   = GW'(BUFFER_MAX_BYTES);
   localparam logic [AW-1:0] ALIGN_ADD  = AW'(HEADER_BYTES + 3);
   localparam logic [AW-1:0] ALIGN_MASK = ~AW'(3);
   localparam logic [CW-1:0] DEPTH_C    = CW'(CHUNK_DEPTH);

   // Commit size for a block count, clamped to the buffer limits.
   function automatic logic [AW-1:0] clamp_commit(input logic [CFG_W-1:0] blocks);
      logic [AW-1:0] c;
      c = AW'({blocks, {BLOCK_SHIFT{1'b0}}});
      if (c < MIN_B) c = MIN_B;
      if (c > MAX_B) c = MAX_B;
      return c;
   endfunction

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    bump_ff, bump_in;
   logic [AW-1:0]    commit_ff, commit_in;
   logic [OFS_W-1:0] opnd_ff, opnd_in;
   logic [AW-1:0]    body_ff, body_in;
   logic [AW-1:0]    chunk_end_ff, chunk_end_in;
   logic [IW-1:0]    scan_ff, scan_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OFS_W-1:0] rsp_body_ff, rsp_body_in;
   status_type       rsp_status_ff, rsp_status_in;

   // RAM port signals.
   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   logic [MW-1:0]    wr_data;
   logic [IW-1:0]    rd_addr;
   logic [MW-1:0]    rd_data;

   // Derived values.
   logic             accept;
   logic [CW-1:0]    count_less;
   logic [IW-1:0]    top_idx;
   logic [AW-1:0]    rd_body;
   logic [OFS_W-1:0] rd_len;
   logic             rd_freed;
   logic             hit;
   logic             at_top;
   logic             at_bottom;
   logic [AW-1:0]    alloc_end;
   logic             stack_full;
   logic             too_large;
   logic             needs_grow;
   logic [GW-1:0]    grow_wide;
   logic [AW-1:0]    grow_n;
   logic [AW-1:0]    quarter;
   logic             can_shrink;
   logic             free_null;

   // Chunk stack: {freed, length, body} per entry.
   saa_ram #(
      .WIDTH (MW),
      .DEPTH (CHUNK_DEPTH)
   ) u_chunk_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Decoding of the current chunk read and the request checks.
   assign accept     = start && (state_ff == ST_IDLE);
   assign count_less = count_ff - CW'(1);
   assign top_idx    = count_less[IW-1:0];
   assign rd_body    = rd_data[AW-1:0];
   assign rd_len     = rd_data[AW+OFS_W-1:AW];
   assign rd_freed   = rd_data[MW-1];
   assign hit        = (rd_body == AW'(opnd_ff));
   assign at_top     = (scan_ff == top_idx);
   assign at_bottom  = (scan_ff == '0);
   assign alloc_end  = body_ff + AW'(opnd_ff);
   assign stack_full = (count_ff >= DEPTH_C);
   assign too_large  = (alloc_end > MAX_B);
   assign needs_grow = (alloc_end > commit_ff);
   assign grow_wide  = {commit_ff, 2'b00};
   assign grow_n     = (grow_wide > MAX_WIDE) ? MAX_B : grow_wide[AW-1:0];
   assign quarter    = commit_ff >> 2;
   assign can_shrink = (quarter >= bump_ff) && (quarter >= MIN_B);
   assign free_null  = (req_free_offset == '0) || (count_ff == '0);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_type == REQ_ALLOC) begin
                  state_in = ST_ALLOC;
               end else if (!free_null) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_ALLOC: begin
            if (stack_full || too_large || !needs_grow) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_GROW;
            end
         end
         ST_GROW: begin
            if (grow_n >= chunk_end_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               if (rd_freed) begin
                  state_in = ST_IDLE;
               end else if (at_top && !at_bottom) begin
                  state_in = ST_POP;
               end else begin
                  state_in = ST_SHRINK;
               end
            end else if (at_bottom) begin
               state_in = ST_IDLE;
            end
         end
         ST_POP: begin
            if (!(rd_freed && !at_bottom)) begin
               state_in = ST_SHRINK;
            end
         end
         ST_SHRINK: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, RAM access and result logic.
   always_comb begin
      count_in      = count_ff;
      bump_in       = bump_ff;
      commit_in     = commit_ff;
      opnd_in       = opnd_ff;
      body_in       = body_ff;
      chunk_end_in  = chunk_end_ff;
      scan_in       = scan_ff;
      rsp_valid_in  = 1'b0;
      rsp_body_in   = rsp_body_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = scan_ff;
      wr_data       = {1'b1, rd_len, rd_body};
      rd_addr       = scan_ff - IW'(1);

      unique case (state_ff)
         ST_IDLE: begin
            // Latch the operand, place the body and fetch the top chunk.
            rd_addr = top_idx;
            if (accept) begin
               opnd_in = (req_type == REQ_ALLOC) ? req_alloc_size : req_free_offset;
               body_in = (bump_ff + ALIGN_ADD) & ALIGN_MASK;
               scan_in = top_idx;
               if (req_type == REQ_FREE && free_null) begin
                  rsp_valid_in  = 1'b1;
                  rsp_body_in   = '0;
                  rsp_status_in = STATUS_FREE_IGNORED;
               end
            end
         end
         ST_ALLOC: begin
            // Check the limits and push the new chunk.
            chunk_end_in = alloc_end;
            rsp_body_in  = '0;
            if (stack_full) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_STACK_FULL;
            end else if (too_large) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NO_SPACE;
            end else begin
               wr_en         = 1'b1;
               wr_addr       = count_ff[IW-1:0];
               wr_data       = {1'b0, opnd_ff, body_ff};
               count_in      = count_ff + CW'(1);
               bump_in       = alloc_end;
               rsp_body_in   = body_ff[OFS_W-1:0];
               rsp_status_in = STATUS_OK;
               rsp_valid_in  = !needs_grow;
            end
         end
         ST_GROW: begin
            // Quadruple the commit one step a cycle until the chunk fits.
            commit_in = grow_n;
            if (grow_n >= chunk_end_ff) begin
               rsp_valid_in = 1'b1;
            end
         end
         ST_SCAN: begin
            // Compare one chunk a cycle from the top downwards.
            rsp_body_in = '0;
            scan_in     = scan_ff - IW'(1);
            if (hit) begin
               if (rd_freed) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_FREE_IGNORED;
               end else if (at_top) begin
                  count_in = count_less;
                  if (at_bottom) begin
                     bump_in = '0;
                  end
               end else begin
                  wr_en = 1'b1;
               end
            end else if (at_bottom) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_FREE_IGNORED;
            end
         end
         ST_POP: begin
            // Pop freed chunks; the first live one sets the bump pointer.
            scan_in = scan_ff - IW'(1);
            if (rd_freed) begin
               count_in = count_less;
               if (at_bottom) begin
                  bump_in = '0;
               end
            end else begin
               bump_in = rd_body + AW'(rd_len);
            end
         end
         ST_SHRINK: begin
            // Quarter the commit once if the quarter still covers the arena and the minimum.
            if (can_shrink) begin
               commit_in = quarter;
            end
            rsp_valid_in  = 1'b1;
            rsp_body_in   = '0;
            rsp_status_in = STATUS_OK;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase

      // A register write re-initialises the arena.
      if (csr_wr_en) begin
         count_in  = '0;
         bump_in   = '0;
         commit_in = clamp_commit(csr_wr_data);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         bump_ff      <= '0;
         commit_ff    <= clamp_commit(CFG_W'(1));
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         bump_ff      <= bump_in;
         commit_ff    <= commit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      opnd_ff       <= opnd_in;
      body_ff       <= body_in;
      chunk_end_ff  <= chunk_end_in;
      scan_ff       <= scan_in;
      rsp_body_ff   <= rsp_body_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Outputs.
   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_body_offset     = rsp_body_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_committed_bytes = commit_ff[OFS_W-1:0];

endmodule

`default_nettype wire

// ----- tb/arena_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arena_result_checker
// Watches the request, result and register ports of the stack arena
// allocator, predicts every result item from its own copy of the arena and
// compares each result item, field by field, with the oldest one awaited.
// ----------------------------------------------------------------------------

module arena_result_checker
   import saa_pkg::*;
#(
   parameter int BUFFER_MAX_BYTES = 16777216,
   parameter int BUFFER_MIN_BYTES = 65536,
   parameter int CHUNK_DEPTH      = 256,
   parameter int HEADER_BYTES     = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  logic             req_type,
   input  logic [OFS_W-1:0] req_alloc_size,
   input  logic [OFS_W-1:0] req_free_offset,
   input  logic             rsp_valid,
   input  logic [OFS_W-1:0] rsp_body_offset,
   input  logic [1:0]       rsp_status,
   input  logic [OFS_W-1:0] rsp_committed_bytes,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,
   output int unsigned      fail_count,
   output int unsigned      pending
);

   // One predicted result item.
   typedef struct {
      logic [OFS_W-1:0] body;
      status_type       status;
      logic [OFS_W-1:0] committed;
   } arena_result_type;

   // Our own copy of the arena: the chunk stack, bump pointer and commit.
   logic [OFS_W-1:0] chunk_start    [CHUNK_DEPTH];
   logic [OFS_W-1:0] chunk_len      [CHUNK_DEPTH];
   bit               chunk_released [CHUNK_DEPTH];
   int unsigned      live_depth;
   longint unsigned  bump_at;
   longint unsigned  commit_bytes;

   arena_result_type awaited_results [$];
   int unsigned      mismatches = 0;

   // Empty the stack and set the commit from a block count, clamped.
   function automatic void arena_reinit(input logic [CFG_W-1:0] blocks);
      longint unsigned bytes;
      bytes = 64'(blocks);
      bytes = bytes << BLOCK_SHIFT;
      if (bytes < BUFFER_MIN_BYTES) bytes = BUFFER_MIN_BYTES;
      if (bytes > BUFFER_MAX_BYTES) bytes = BUFFER_MAX_BYTES;
      commit_bytes = bytes;
      for (int i = 0; i < CHUNK_DEPTH; i++) begin
         chunk_start[i]    = '0;
         chunk_len[i]      = '0;
         chunk_released[i] = 1'b0;
      end
      live_depth = 0;
      bump_at    = 0;
   endfunction

   // Place a chunk after the header gap, growing the commit by fours if needed.
   function automatic arena_result_type predict_alloc(input logic [OFS_W-1:0] size);
      arena_result_type r;
      longint unsigned  body;
      longint unsigned  tail;
      longint unsigned  grown;
      r.body   = '0;
      r.status = STATUS_OK;
      if (live_depth >= CHUNK_DEPTH) begin
         r.status = STATUS_STACK_FULL;
      end else begin
         body = (bump_at + HEADER_BYTES + 3) & ~64'd3;
         tail = body + size;
         if (tail > BUFFER_MAX_BYTES) begin
            r.status = STATUS_NO_SPACE;
         end else begin
            if (tail > commit_bytes) begin
               grown = commit_bytes;
               while (grown < tail) begin
                  grown = grown * 4;
                  if (grown > BUFFER_MAX_BYTES) grown = BUFFER_MAX_BYTES;
               end
               commit_bytes = grown;
            end
            chunk_start[live_depth]    = body[OFS_W-1:0];
            chunk_len[live_depth]      = size;
            chunk_released[live_depth] = 1'b0;
            live_depth++;
            bump_at = tail;
            r.body  = body[OFS_W-1:0];
         end
      end
      r.committed = commit_bytes[OFS_W-1:0];
      return r;
   endfunction

   // Mark a chunk released, pop released chunks from the top, shrink once.
   function automatic arena_result_type predict_free(input logic [OFS_W-1:0] ofs);
      arena_result_type r;
      bit               found;
      int unsigned      hit;
      longint unsigned  quarter;
      r.body   = '0;
      r.status = STATUS_FREE_IGNORED;
      found    = 1'b0;
      hit      = 0;
      if (ofs != '0) begin
         for (int i = live_depth; i > 0; i--) begin
            if (!found && chunk_start[i-1] == ofs) begin
               found = 1'b1;
               hit   = i - 1;
            end
         end
         if (found && !chunk_released[hit]) begin
            r.status            = STATUS_OK;
            chunk_released[hit] = 1'b1;
            while (live_depth > 0 && chunk_released[live_depth-1]) begin
               chunk_released[live_depth-1] = 1'b0;
               live_depth--;
            end
            if (live_depth > 0)
               bump_at = longint'(chunk_start[live_depth-1]) + chunk_len[live_depth-1];
            else
               bump_at = 0;
            quarter = commit_bytes / 4;
            if (quarter >= bump_at && quarter >= BUFFER_MIN_BYTES) commit_bytes = quarter;
         end
      end
      r.committed = commit_bytes[OFS_W-1:0];
      return r;
   endfunction

   // Compare result items first, then take in register writes and new items.
   always @(posedge clock) begin : watch
      arena_result_type oldest;
      if (reset) begin
         arena_reinit(CFG_W'(1));
         awaited_results.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               mismatches++;
               $display("%0t: result item with none awaited: expected nothing, %s",
                        $time, "got an item");
               $display("%0t:   got body %0d status %0d committed %0d",
                        $time, rsp_body_offset, rsp_status, rsp_committed_bytes);
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_body_offset !== oldest.body) begin
                  mismatches++;
                  $display("%0t: body_offset expected %0d, got %0d",
                           $time, oldest.body, rsp_body_offset);
               end
               if (rsp_status !== oldest.status) begin
                  mismatches++;
                  $display("%0t: status expected %0d, got %0d",
                           $time, oldest.status, rsp_status);
               end
               if (rsp_committed_bytes !== oldest.committed) begin
                  mismatches++;
                  $display("%0t: committed_bytes expected %0d, got %0d",
                           $time, oldest.committed, rsp_committed_bytes);
               end
            end
         end
         if (csr_wr_en) arena_reinit(csr_wr_data);
         if (start && !busy) begin
            if (req_type == REQ_ALLOC)
               awaited_results.push_back(predict_alloc(req_alloc_size));
            else
               awaited_results.push_back(predict_free(req_free_offset));
         end
      end
      pending    <= awaited_results.size();
      fail_count <= mismatches;
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the stack arena allocator with a short directed run, then random
// mixes of allocates and frees under several commit settings and idle
// rates, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------

module testbench;
   import saa_pkg::*;

   localparam int BUFFER_MAX_BYTES = 16777216;
   localparam int BUFFER_MIN_BYTES = 65536;
   localparam int CHUNK_DEPTH      = 256;
   localparam int HEADER_BYTES     = 8;

   logic             clock           = 1'b0;
   logic             reset           = 1'b1;
   logic             start           = 1'b0;
   logic             req_type        = REQ_ALLOC;
   logic [OFS_W-1:0] req_alloc_size  = '0;
   logic [OFS_W-1:0] req_free_offset = '0;
   logic             csr_wr_en       = 1'b0;
   logic [CFG_W-1:0] csr_wr_data     = '0;

   logic             busy;
   logic             rsp_valid;
   logic [OFS_W-1:0] rsp_body_offset;
   logic [1:0]       rsp_status;
   logic [OFS_W-1:0] rsp_committed_bytes;

   int unsigned      fail_count;
   int unsigned      pending;

   int unsigned      idle_pct      = 0;
   int unsigned      items_sent    = 0;
   int unsigned      settings_used = 1;
   int unsigned      status_seen [4] = '{default: 0};

   // Bodies handed out and not yet released, in stack order, and a few
   // recently released ones for double frees.
   logic [OFS_W-1:0] live_bodies     [$];
   logic [OFS_W-1:0] released_bodies [$];

   always #2 clock = ~clock;

   stack_arena_allocator #(
      .BUFFER_MAX_BYTES (BUFFER_MAX_BYTES),
      .BUFFER_MIN_BYTES (BUFFER_MIN_BYTES),
      .CHUNK_DEPTH      (CHUNK_DEPTH),
      .HEADER_BYTES     (HEADER_BYTES)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_alloc_size      (req_alloc_size),
      .req_free_offset     (req_free_offset),
      .rsp_valid           (rsp_valid),
      .rsp_body_offset     (rsp_body_offset),
      .rsp_status          (rsp_status),
      .rsp_committed_bytes (rsp_committed_bytes),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   arena_result_checker #(
      .BUFFER_MAX_BYTES (BUFFER_MAX_BYTES),
      .BUFFER_MIN_BYTES (BUFFER_MIN_BYTES),
      .CHUNK_DEPTH      (CHUNK_DEPTH),
      .HEADER_BYTES     (HEADER_BYTES)
   ) checker_i (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_alloc_size      (req_alloc_size),
      .req_free_offset     (req_free_offset),
      .rsp_valid           (rsp_valid),
      .rsp_body_offset     (rsp_body_offset),
      .rsp_status          (rsp_status),
      .rsp_committed_bytes (rsp_committed_bytes),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   // Collect handed-out bodies mid-cycle, away from the driving edge.
   always @(negedge clock) begin
      if (rsp_valid) begin
         status_seen[rsp_status]++;
         if (rsp_body_offset != '0) live_bodies.push_back(rsp_body_offset);
      end
   end

   // Offer one item, after a random idle stretch, and wait until it is taken.
   task automatic send_item(input logic kind, input logic [OFS_W-1:0] size,
                            input logic [OFS_W-1:0] ofs);
      while ($urandom_range(99) < idle_pct) begin
         start           <= 1'b0;
         req_type        <= 1'($urandom_range(1));
         req_alloc_size  <= OFS_W'($urandom);
         req_free_offset <= OFS_W'($urandom);
         @(posedge clock);
      end
      start           <= 1'b1;
      req_type        <= kind;
      req_alloc_size  <= size;
      req_free_offset <= ofs;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // Wait until every awaited result item has come and the block is idle.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
   endtask

   // Re-initialise the arena with a new commit setting while idle.
   task automatic write_commit(input logic [CFG_W-1:0] blocks);
      drain();
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= blocks;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      live_bodies.delete();
      released_bodies.delete();
      settings_used++;
   endtask

   // Remove a live body from the list and remember it as released.
   function automatic logic [OFS_W-1:0] take_live(input int unsigned idx);
      logic [OFS_W-1:0] body;
      if (idx >= live_bodies.size()) return '0;
      body = live_bodies[idx];
      live_bodies.delete(idx);
      released_bodies.push_back(body);
      if (released_bodies.size() > 16) released_bodies.delete(0);
      return body;
   endfunction

   // Mostly small sizes, with the odd one large enough to grow the commit.
   function automatic logic [OFS_W-1:0] random_size();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 65) return OFS_W'($urandom_range(255));
      else if (pick < 88) return OFS_W'($urandom_range(65535));
      else if (pick < 97) return OFS_W'($urandom_range(1 << 20));
      else return OFS_W'($urandom_range(BUFFER_MAX_BYTES));
   endfunction

   // Well-formed allocates and frees of live bodies, with some noise mixed in.
   task automatic run_mixed(input int unsigned count);
      int unsigned pick;
      int unsigned idx;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            send_item(REQ_FREE, OFS_W'($urandom), '0);
         end else if (pick < 9) begin
            send_item(REQ_FREE, OFS_W'($urandom), OFS_W'($urandom));
         end else if (pick < 13 && released_bodies.size() != 0) begin
            idx = $urandom_range(released_bodies.size() - 1);
            send_item(REQ_FREE, '0, released_bodies[idx]);
         end else if (pick < 16) begin
            send_item(REQ_ALLOC, OFS_W'($urandom), OFS_W'($urandom));
         end else if (pick < 58 || live_bodies.size() == 0) begin
            send_item(REQ_ALLOC, random_size(), OFS_W'($urandom));
         end else begin
            // Half the frees hit the top chunk, the rest a random live chunk.
            if ($urandom_range(1) == 1) idx = live_bodies.size() - 1;
            else idx = $urandom_range(live_bodies.size() - 1);
            send_item(REQ_FREE, OFS_W'($urandom), take_live(idx));
         end
      end
   endtask

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed run under the reset commit of one block, no idling.
      idle_pct = 0;
      // A null free and a free on an empty stack are both ignored.
      send_item(REQ_FREE, '0, '0);
      send_item(REQ_FREE, '0, OFS_W'(8));
      // Three small chunks, the last two with unaligned ends.
      send_item(REQ_ALLOC, '0, '0);
      send_item(REQ_ALLOC, OFS_W'(1), '0);
      send_item(REQ_ALLOC, OFS_W'(3), '0);
      drain();
      // Release the middle chunk (left on the stack), release it again,
      // then the top one, which pops both.
      send_item(REQ_FREE, '0, take_live(1));
      send_item(REQ_FREE, '0, released_bodies[$]);
      send_item(REQ_FREE, '0, take_live(live_bodies.size() - 1));
      // Growth by one step and by more than one, then a size that can never fit.
      send_item(REQ_ALLOC, OFS_W'(65536), '0);
      send_item(REQ_ALLOC, OFS_W'(4000000), '0);
      send_item(REQ_ALLOC, {OFS_W{1'b1}}, '0);
      // Unknown offsets: an odd one and one with every bit set.
      send_item(REQ_FREE, '0, OFS_W'(12345));
      send_item(REQ_FREE, {OFS_W{1'b1}}, {OFS_W{1'b1}});
      drain();
      // Release from the top until the stack is empty; the commit shrinks.
      while (live_bodies.size() != 0)
         send_item(REQ_FREE, '0, take_live(live_bodies.size() - 1));
      // A chunk ending exactly at the maximum, then one that cannot follow it.
      send_item(REQ_ALLOC, OFS_W'(BUFFER_MAX_BYTES - HEADER_BYTES), '0);
      send_item(REQ_ALLOC, '0, '0);
      drain();
      // Release it, then release the same body after it has been popped.
      send_item(REQ_FREE, '0, take_live(0));
      send_item(REQ_FREE, '0, released_bodies[$]);

      // Random mixes under several commit settings and idle rates.
      write_commit(CFG_W'(1));
      idle_pct = 0;
      run_mixed(40);

      write_commit(CFG_W'(0));
      idle_pct = 53;
      run_mixed(50);

      // Fill the chunk stack past its depth, then release chunks at random.
      write_commit(CFG_W'(256));
      idle_pct = 7;
      repeat (CHUNK_DEPTH + 4)
         send_item(REQ_ALLOC, OFS_W'($urandom_range(64)), OFS_W'($urandom));
      repeat (25) begin
         if (live_bodies.size() != 0)
            send_item(REQ_FREE, '0, take_live($urandom_range(live_bodies.size() - 1)));
      end

      write_commit({CFG_W{1'b1}});
      idle_pct = 53;
      run_mixed(30);

      write_commit(CFG_W'($urandom_range(255, 2)));
      idle_pct = 0;
      run_mixed(30);

      drain();
      repeat (20) @(posedge clock);

      $display("Ran %0d request items over %0d commit settings, including a full chunk stack.",
               items_sent, settings_used);
      $display("Results: %0d ok, %0d out of space, %0d frees ignored, %0d stack full.",
               status_seen[STATUS_OK], status_seen[STATUS_NO_SPACE],
               status_seen[STATUS_FREE_IGNORED], status_seen[STATUS_STACK_FULL]);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
